// ===== rtl/acc_pkg.sv =====
package acc_pkg;

	localparam int DATA_DEPTH  = 256;
	localparam int STACK_DEPTH = 16;
	localparam int DA_W = (DATA_DEPTH > 1) ? $clog2(DATA_DEPTH) : 1;
	localparam int SA_W = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
	localparam int SL_W = $clog2(STACK_DEPTH + 1);

	localparam logic [7:0] OP_HALT = 8'h00;
	localparam logic [7:0] OP_SET0 = 8'h01;
	localparam logic [7:0] OP_SET1 = 8'h02;
	localparam logic [7:0] OP_ADD  = 8'h03;
	localparam logic [7:0] OP_STOR = 8'h04;
	localparam logic [7:0] OP_PRT  = 8'h05;
	localparam logic [7:0] OP_MULT = 8'h07;
	localparam logic [7:0] OP_DIV  = 8'h08;
	localparam logic [7:0] OP_SUB  = 8'h09;
	localparam logic [7:0] OP_JEQ  = 8'h0A;
	localparam logic [7:0] OP_JNE  = 8'h0B;
	localparam logic [7:0] OP_JLT  = 8'h0C;
	localparam logic [7:0] OP_JGT  = 8'h0D;
	localparam logic [7:0] OP_CALL = 8'h0E;
	localparam logic [7:0] OP_RET  = 8'h0F;
	localparam logic [7:0] OP_INT  = 8'h10;
	localparam logic [7:0] OP_CMP  = 8'h11;
	localparam logic [7:0] OP_JNZ  = 8'h12;
	localparam logic [7:0] OP_JMP  = 8'h13;
	localparam logic [7:0] OP_JZ   = 8'h14;
	localparam logic [7:0] OP_INC0 = 8'h15;
	localparam logic [7:0] OP_INC1 = 8'h16;
	localparam logic [7:0] OP_DEC0 = 8'h17;
	localparam logic [7:0] OP_DEC1 = 8'h18;
	localparam logic [7:0] OP_LD0  = 8'h19;
	localparam logic [7:0] OP_LD1  = 8'h1A;
	localparam logic [7:0] OP_TST  = 8'h1B;

	localparam logic [2:0] EV_NONE      = 3'd0;
	localparam logic [2:0] EV_PRINT     = 3'd1;
	localparam logic [2:0] EV_SERVICE   = 3'd2;
	localparam logic [2:0] EV_BAD       = 3'd3;
	localparam logic [2:0] EV_DIVZERO   = 3'd4;
	localparam logic [2:0] EV_OVERFLOW  = 3'd5;
	localparam logic [2:0] EV_UNDERFLOW = 3'd6;

	typedef struct packed {
		logic       clr_start;
		logic       clr_step;
		logic       load;
		logic       rd_start;
		logic       exec;
		logic       div_start;
		logic       div_step;
		logic       div_done;
	} cmd_t;

	typedef struct packed {
		logic       clr_last;
		logic       is_div;
		logic       div_last;
	} sts_t;

endpackage

// ===== rtl/accumulator_cpu_core_top.sv =====
// Accumulator CPU core: one instruction word (opcode, operand) in, one result word out.
// After reset the data store is swept to zero before the first word is taken. Each
// instruction goes through accept, store read and execute into the result register;
// execute waits while the output is stalled, and DIV first runs its bit-serial divider.
module accumulator_cpu_core_top (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] opcode,
	input  logic [7:0] operand,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] next_pc,
	output logic       halted,
	output logic [2:0] event_kind,
	output logic [7:0] print_address,
	output logic [7:0] print_value,
	output logic [7:0] service_code,
	output logic [7:0] service_arg_a,
	output logic [7:0] service_arg_b
);
	import acc_pkg::*;

	cmd_t cmd;
	sts_t sts;

	acc_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.out_valid(out_valid), .out_stall(out_stall), .cmd(cmd), .sts(sts)
	);

	acc_dp u_dp (
		.clk(clk), .arst_n(arst_n), .opcode(opcode), .operand(operand),
		.cmd(cmd), .sts(sts), .next_pc(next_pc), .halted(halted),
		.event_kind(event_kind), .print_address(print_address),
		.print_value(print_value), .service_code(service_code),
		.service_arg_a(service_arg_a), .service_arg_b(service_arg_b)
	);
endmodule

// ===== rtl/acc_ctrl.sv =====
module acc_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_stall,
	output logic          out_valid,
	input  logic          out_stall,
	output acc_pkg::cmd_t cmd,
	input  acc_pkg::sts_t sts
);
	import acc_pkg::*;

	localparam logic [2:0] S_RST  = 3'd0;
	localparam logic [2:0] S_CLR  = 3'd1;
	localparam logic [2:0] S_IDLE = 3'd2;
	localparam logic [2:0] S_RD   = 3'd3;
	localparam logic [2:0] S_EXEC = 3'd4;
	localparam logic [2:0] S_DIV  = 3'd5;
	localparam logic [2:0] S_FIN  = 3'd6;

	logic [2:0] state_q;
	logic       out_valid_q;
	logic       free;
	logic       fire;

	assign out_valid = out_valid_q;
	assign free      = !out_valid_q || !out_stall;
	assign in_stall  = !(state_q == S_IDLE);
	assign fire      = free && ((state_q == S_EXEC && !sts.is_div) || state_q == S_FIN);

	always_comb begin
		cmd = '0;
		case (state_q)
			S_RST:  cmd.clr_start = 1'b1;
			S_CLR:  cmd.clr_step  = 1'b1;
			S_IDLE: cmd.load      = in_valid;
			S_RD:   cmd.rd_start  = 1'b1;
			S_EXEC: begin
				if (sts.is_div) cmd.div_start = 1'b1;
				else cmd.exec = free;
			end
			S_DIV:  cmd.div_step  = 1'b1;
			S_FIN:  cmd.div_done  = free;
			default: cmd = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_RST;
			out_valid_q <= 1'b0;
		end else begin
			if (fire) out_valid_q <= 1'b1;
			else if (out_valid_q && !out_stall) out_valid_q <= 1'b0;
			case (state_q)
				S_RST:  state_q <= S_CLR;
				S_CLR:  if (sts.clr_last) state_q <= S_IDLE;
				S_IDLE: if (in_valid) state_q <= S_RD;
				S_RD:   state_q <= S_EXEC;
				S_EXEC: begin
					if (sts.is_div) state_q <= S_DIV;
					else if (free) state_q <= S_IDLE;
				end
				S_DIV:  if (sts.div_last) state_q <= S_FIN;
				S_FIN:  if (free) state_q <= S_IDLE;
				default: state_q <= S_RST;
			endcase
		end
	end
endmodule

// ===== rtl/acc_dp.sv =====
module acc_dp (
	input  logic          clk,
	input  logic          arst_n,
	input  logic [7:0]    opcode,
	input  logic [7:0]    operand,
	input  acc_pkg::cmd_t cmd,
	output acc_pkg::sts_t sts,
	output logic [7:0]    next_pc,
	output logic          halted,
	output logic [2:0]    event_kind,
	output logic [7:0]    print_address,
	output logic [7:0]    print_value,
	output logic [7:0]    service_code,
	output logic [7:0]    service_arg_a,
	output logic [7:0]    service_arg_b
);
	import acc_pkg::*;

	logic [7:0] mem_q [DATA_DEPTH];
	logic [7:0] stk_q [STACK_DEPTH];
	logic [7:0] op_q, arg_q, a_q, b_q, pc_q, dp_q, rd_q, sk_q;
	logic       gt_q, lt_q, zf_q, nz_q, hf_q;
	logic [SL_W-1:0] sl_q;
	logic [DA_W-1:0] clr_q;
	logic [7:0] rem_q, quo_q;
	logic [3:0] dcnt_q;
	logic [15:0] prod;
	logic [8:0] trial;
	logic       in_rng;

	logic [7:0] npc, na, nb, pa, pv, sc;
	logic [2:0] ev;
	logic       cond, jmp, wr, push, pop, ngt, nlt, nzf, nnz, nhf;

	assign in_rng = {24'd0, arg_q} < DATA_DEPTH;
	assign prod   = a_q * b_q;
	assign trial  = {rem_q, quo_q[7]} - {1'b0, b_q};

	assign sts.clr_last = clr_q == DA_W'(DATA_DEPTH - 1);
	assign sts.is_div   = !hf_q && op_q == OP_DIV && b_q != 8'd0;
	assign sts.div_last = dcnt_q == 4'd7;

	always_comb begin
		npc = pc_q + 8'd1; na = a_q; nb = b_q; ev = EV_NONE;
		pa = '0; pv = '0; sc = '0; cond = 1'b0; jmp = 1'b0;
		wr = 1'b0; push = 1'b0; pop = 1'b0;
		ngt = gt_q; nlt = lt_q; nzf = zf_q; nnz = nz_q; nhf = hf_q;
		if (hf_q) begin
			npc = pc_q;
		end else begin
			case (op_q)
				OP_HALT: nhf = 1'b1;
				OP_SET0: begin na = arg_q; npc = pc_q + 8'd2; end
				OP_SET1: begin nb = arg_q; npc = pc_q + 8'd2; end
				OP_ADD:  na = a_q + b_q;
				OP_STOR: begin wr = 1'b1; npc = pc_q + 8'd2; end
				OP_PRT:  begin
					ev = EV_PRINT; pa = arg_q; pv = rd_q; npc = pc_q + 8'd2;
				end
				OP_MULT: na = prod[7:0];
				OP_DIV:  if (b_q == 8'd0) ev = EV_DIVZERO;
				OP_SUB:  na = a_q - b_q;
				OP_JEQ:  begin jmp = 1'b1; cond = !(gt_q || lt_q); end
				OP_JNE:  begin jmp = 1'b1; cond = gt_q || lt_q; end
				OP_JLT:  begin jmp = 1'b1; cond = lt_q; end
				OP_JGT:  begin jmp = 1'b1; cond = gt_q; end
				OP_CALL: begin
					if ({{(32-SL_W){1'b0}}, sl_q} >= STACK_DEPTH) begin
						ev = EV_OVERFLOW; npc = pc_q + 8'd2;
					end else begin
						push = 1'b1; npc = arg_q;
					end
				end
				OP_RET:  begin
					if (sl_q == '0) ev = EV_UNDERFLOW;
					else begin pop = 1'b1; npc = sk_q; end
				end
				OP_INT:  begin
					ev = EV_SERVICE; sc = arg_q; npc = pc_q + 8'd2;
				end
				OP_CMP:  begin ngt = a_q > b_q; nlt = a_q < b_q; end
				OP_JNZ:  begin jmp = 1'b1; cond = nz_q; end
				OP_JMP:  begin jmp = 1'b1; cond = 1'b1; end
				OP_JZ:   begin jmp = 1'b1; cond = zf_q; end
				OP_INC0: na = a_q + 8'd1;
				OP_INC1: nb = b_q + 8'd1;
				OP_DEC0: na = a_q - 8'd1;
				OP_DEC1: nb = b_q - 8'd1;
				OP_LD0:  begin na = rd_q; npc = pc_q + 8'd2; end
				OP_LD1:  begin nb = rd_q; npc = pc_q + 8'd2; end
				OP_TST:  begin nzf = a_q == 8'd0; nnz = a_q != 8'd0; end
				default: ev = EV_BAD;
			endcase
			if (jmp) npc = cond ? arg_q : pc_q + 8'd2;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.clr_step) mem_q[clr_q] <= 8'd0;
		else if (cmd.exec && wr && in_rng) mem_q[arg_q[DA_W-1:0]] <= a_q;
		if (cmd.rd_start) rd_q <= in_rng ? mem_q[arg_q[DA_W-1:0]] : 8'd0;
		if (cmd.exec && push) stk_q[sl_q[SA_W-1:0]] <= pc_q + 8'd2;
		if (cmd.rd_start) sk_q <= stk_q[SA_W'(sl_q - SL_W'(1))];
		if (cmd.load) begin op_q <= opcode; arg_q <= operand; end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			a_q <= '0; b_q <= '0; pc_q <= '0; dp_q <= '0; sl_q <= '0;
			gt_q <= 1'b0; lt_q <= 1'b0; zf_q <= 1'b0; nz_q <= 1'b0; hf_q <= 1'b0;
			clr_q <= '0; dcnt_q <= '0; rem_q <= '0; quo_q <= '0;
			next_pc <= '0; halted <= 1'b0; event_kind <= EV_NONE;
			print_address <= '0; print_value <= '0; service_code <= '0;
			service_arg_a <= '0; service_arg_b <= '0;
		end else begin
			if (cmd.clr_start) clr_q <= '0;
			else if (cmd.clr_step) clr_q <= clr_q + DA_W'(1);
			if (cmd.div_start) begin
				rem_q <= '0; quo_q <= a_q; dcnt_q <= '0;
			end else if (cmd.div_step) begin
				if (!trial[8]) rem_q <= trial[7:0];
				else rem_q <= {rem_q[6:0], quo_q[7]};
				quo_q <= {quo_q[6:0], !trial[8]};
				dcnt_q <= dcnt_q + 4'd1;
			end
			if (cmd.div_done) begin
				a_q <= quo_q; pc_q <= pc_q + 8'd1;
				next_pc <= pc_q + 8'd1; halted <= 1'b0; event_kind <= EV_NONE;
				print_address <= '0; print_value <= '0; service_code <= '0;
				service_arg_a <= '0; service_arg_b <= '0;
			end
			if (cmd.exec) begin
				a_q <= na; b_q <= nb; pc_q <= npc;
				gt_q <= ngt; lt_q <= nlt; zf_q <= nzf; nz_q <= nnz; hf_q <= nhf;
				if (!hf_q && (op_q == OP_STOR || op_q == OP_PRT)) dp_q <= arg_q;
				if (push) sl_q <= sl_q + SL_W'(1);
				else if (pop) sl_q <= sl_q - SL_W'(1);
				next_pc <= npc; halted <= nhf; event_kind <= ev;
				print_address <= pa; print_value <= pv; service_code <= sc;
				service_arg_a <= (ev == EV_SERVICE) ? a_q : 8'd0;
				service_arg_b <= (ev == EV_SERVICE) ? b_q : 8'd0;
			end
		end
	end
endmodule

// ===== dv/tb_accumulator_cpu_core_top.sv =====
module tb_accumulator_cpu_core_top;
	timeunit 1ns;
	timeprecision 1ps;

	import acc_pkg::*;

	typedef struct packed {
		logic [7:0] npc;
		logic       halt;
		logic [2:0] ev;
		logic [7:0] paddr;
		logic [7:0] pval;
		logic [7:0] scode;
		logic [7:0] sa;
		logic [7:0] sb;
	} cpu_word_t;

	typedef struct packed {
		logic [7:0] op;
		logic [7:0] arg;
		logic       typed;
		logic [7:0] npc;
		logic [2:0] ev;
		logic [7:0] paddr;
		logic [7:0] pval;
	} plan_row_t;

	localparam int PLAN_LEN = 31;

	logic       clk;
	logic       arst_n;
	logic       in_valid;
	logic       in_stall;
	logic [7:0] opcode;
	logic [7:0] operand;
	logic       out_valid;
	logic       out_stall;
	logic [7:0] next_pc;
	logic       halted;
	logic [2:0] event_kind;
	logic [7:0] print_address;
	logic [7:0] print_value;
	logic [7:0] service_code;
	logic [7:0] service_arg_a;
	logic [7:0] service_arg_b;

	accumulator_cpu_core_top dut (.*);

	logic [7:0] reg_a, reg_b, pc, dptr;
	logic       gt_f, lt_f, z_f, nz_f, halt_f;
	logic [7:0] dmem [DATA_DEPTH];
	logic [7:0] rstack [STACK_DEPTH];
	int         depth;

	cpu_word_t  pending_words [$];
	int         mismatches;
	int         idle_mode;
	plan_row_t  plan [PLAN_LEN];

	initial begin
		clk = 1'b0;
	end

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic logic [7:0] mem_read(logic [7:0] addr);
		return (int'(addr) < DATA_DEPTH) ? dmem[addr] : 8'h00;
	endfunction

	function automatic cpu_word_t execute(logic [7:0] op, logic [7:0] arg);
		cpu_word_t w;
		logic [7:0] pc1, pc2;
		logic jump, cond;
		w = '0;
		pc1 = pc + 8'd1;
		pc2 = pc + 8'd2;
		w.npc = pc1;
		w.ev = EV_NONE;
		jump = 1'b0;
		cond = 1'b0;
		if (halt_f) begin
			w.npc = pc;
		end else begin
			case (op)
				OP_HALT: halt_f = 1'b1;
				OP_SET0: begin reg_a = arg; w.npc = pc2; end
				OP_SET1: begin reg_b = arg; w.npc = pc2; end
				OP_ADD:  reg_a = reg_a + reg_b;
				OP_STOR: begin
					dptr = arg;
					if (int'(arg) < DATA_DEPTH) dmem[arg] = reg_a;
					w.npc = pc2;
				end
				OP_PRT: begin
					dptr = arg;
					w.ev = EV_PRINT;
					w.paddr = arg;
					w.pval = mem_read(arg);
					w.npc = pc2;
				end
				OP_MULT: reg_a = reg_a * reg_b;
				OP_DIV: begin
					if (reg_b == 8'd0) w.ev = EV_DIVZERO;
					else reg_a = reg_a / reg_b;
				end
				OP_SUB: reg_a = reg_a - reg_b;
				OP_JEQ: begin jump = 1'b1; cond = !(gt_f || lt_f); end
				OP_JNE: begin jump = 1'b1; cond = gt_f || lt_f; end
				OP_JLT: begin jump = 1'b1; cond = lt_f; end
				OP_JGT: begin jump = 1'b1; cond = gt_f; end
				OP_CALL: begin
					if (depth >= STACK_DEPTH) begin
						w.ev = EV_OVERFLOW;
						w.npc = pc2;
					end else begin
						rstack[depth] = pc2;
						depth++;
						w.npc = arg;
					end
				end
				OP_RET: begin
					if (depth == 0) begin
						w.ev = EV_UNDERFLOW;
					end else begin
						depth--;
						w.npc = rstack[depth];
					end
				end
				OP_INT: begin
					w.ev = EV_SERVICE;
					w.scode = arg;
					w.sa = reg_a;
					w.sb = reg_b;
					w.npc = pc2;
				end
				OP_CMP: begin
					gt_f = reg_a > reg_b;
					lt_f = reg_a < reg_b;
				end
				OP_JNZ:  begin jump = 1'b1; cond = nz_f; end
				OP_JMP:  begin jump = 1'b1; cond = 1'b1; end
				OP_JZ:   begin jump = 1'b1; cond = z_f; end
				OP_INC0: reg_a = reg_a + 8'd1;
				OP_INC1: reg_b = reg_b + 8'd1;
				OP_DEC0: reg_a = reg_a - 8'd1;
				OP_DEC1: reg_b = reg_b - 8'd1;
				OP_LD0:  begin reg_a = mem_read(arg); w.npc = pc2; end
				OP_LD1:  begin reg_b = mem_read(arg); w.npc = pc2; end
				OP_TST: begin
					z_f = reg_a == 8'd0;
					nz_f = reg_a != 8'd0;
				end
				default: w.ev = EV_BAD;
			endcase
			if (jump) w.npc = cond ? arg : pc2;
			pc = w.npc;
		end
		w.halt = halt_f;
		return w;
	endfunction

	task automatic issue(logic [7:0] op, logic [7:0] arg, logic typed, cpu_word_t typed_word);
		int gap;
		cpu_word_t w;
		gap = 0;
		if (idle_mode == 0 && $urandom_range(99) < 36) gap = $urandom_range(1, 4);
		if (idle_mode == 1 && $urandom_range(99) < 48) gap = $urandom_range(1, 4);
		@(negedge clk);
		if (gap > 0) begin
			in_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid = 1'b1;
		opcode = op;
		operand = arg;
		do @(posedge clk); while (in_stall);
		w = execute(op, arg);
		pending_words.push_back(typed ? typed_word : w);
	endtask

	task automatic issue_random;
		logic [7:0] op;
		int pick;
		pick = $urandom_range(99);
		if (pick < 8) begin
			op = (pick < 2) ? 8'h06 : 8'($urandom_range(8'h1C, 8'hFF));
		end else begin
			do op = 8'($urandom_range(OP_SET0, OP_TST)); while (op == 8'h06);
		end
		issue(op, 8'($urandom), 1'b0, '0);
	endtask

	task automatic stack_burst;
		for (int i = 0; i <= STACK_DEPTH; i++) issue(OP_CALL, 8'($urandom), 1'b0, '0);
		for (int i = 0; i <= STACK_DEPTH; i++) issue(OP_RET, 8'($urandom), 1'b0, '0);
	endtask

	always @(negedge clk) begin
		if (idle_mode == 0) out_stall = $urandom_range(99) < 48;
		else if (idle_mode == 1) out_stall = $urandom_range(99) < 36;
		else out_stall = 1'b0;
	end

	always @(posedge clk) begin
		cpu_word_t got, want;
		if (arst_n && out_valid && !out_stall) begin
			got = '{next_pc, halted, event_kind, print_address, print_value,
				service_code, service_arg_a, service_arg_b};
			if (pending_words.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected word: %h", got);
			end else begin
				want = pending_words.pop_front();
				if (got.npc !== want.npc || got.halt !== want.halt || got.ev !== want.ev
						|| got.paddr !== want.paddr || got.pval !== want.pval
						|| got.scode !== want.scode || got.sa !== want.sa
						|| got.sb !== want.sb) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: pc %h/%h halt %b/%b ev %0d/%0d",
							want.npc, got.npc, want.halt, got.halt, want.ev, got.ev,
							" prt %h:%h/%h:%h",
							want.paddr, want.pval, got.paddr, got.pval,
							" int %h %h %h/%h %h %h",
							want.scode, want.sa, want.sb, got.scode, got.sa, got.sb);
				end
			end
		end
	end

	initial begin
		#2_000_000;
		$display("FAIL");
		$finish;
	end

	initial begin
		cpu_word_t tw;
		arst_n = 1'b0;
		in_valid = 1'b0;
		opcode = 8'h00;
		operand = 8'h00;
		out_stall = 1'b0;
		idle_mode = 0;
		mismatches = 0;
		reg_a = '0; reg_b = '0; pc = '0; dptr = '0;
		gt_f = 0; lt_f = 0; z_f = 0; nz_f = 0; halt_f = 0;
		depth = 0;
		for (int i = 0; i < DATA_DEPTH; i++) dmem[i] = '0;
		for (int i = 0; i < STACK_DEPTH; i++) rstack[i] = '0;

		plan = '{
			'{OP_PRT,  8'hFF, 1'b1, 8'h02, EV_PRINT,     8'hFF, 8'h00},
			'{OP_DIV,  8'h00, 1'b1, 8'h03, EV_DIVZERO,   8'h00, 8'h00},
			'{OP_RET,  8'h00, 1'b1, 8'h04, EV_UNDERFLOW, 8'h00, 8'h00},
			'{8'h06,   8'h00, 1'b1, 8'h05, EV_BAD,       8'h00, 8'h00},
			'{8'hFF,   8'hFF, 1'b1, 8'h06, EV_BAD,       8'h00, 8'h00},
			'{8'h1C,   8'h00, 1'b1, 8'h07, EV_BAD,       8'h00, 8'h00},
			'{OP_SET0, 8'hFF, 1'b0, 8'h00, EV_NONE,      8'h00, 8'h00},
			'{OP_SET1, 8'hFF, 1'b0, 8'h00, EV_NONE,      8'h00, 8'h00},
			'{OP_ADD,  8'h00, 1'b0, 8'h00, EV_NONE,      8'h00, 8'h00},
			'{OP_MULT, 8'h00, 1'b0, 8'h00, EV_NONE,      8'h00, 8'h00},
			'{OP_SUB,  8'h00, 1'b0, 8'h00, EV_NONE,      8'h00, 8'h00},
			'{OP_STOR, 8'hFF, 1'b0, 8'h00, EV_NONE,      8'h00, 8'h00},
			'{OP_LD1,  8'hFF, 1'b0, 8'h00, EV_NONE,      8'h00, 8'h00},
			'{OP_DIV,  8'h00, 1'b0, 8'h00, EV_NONE,      8'h00, 8'h00},
			'{OP_INC0, 8'h00, 1'b0, 8'h00, EV_NONE,      8'h00, 8'h00},
			'{OP_INC1, 8'h00, 1'b0, 8'h00, EV_NONE,      8'h00, 8'h00},
			'{OP_DEC1, 8'h00, 1'b0, 8'h00, EV_NONE,      8'h00, 8'h00},
			'{OP_CMP,  8'h00, 1'b0, 8'h00, EV_NONE,      8'h00, 8'h00},
			'{OP_JEQ,  8'h40, 1'b0, 8'h00, EV_NONE,      8'h00, 8'h00},
			'{OP_JNE,  8'hF0, 1'b0, 8'h00, EV_NONE,      8'h00, 8'h00},
			'{OP_JLT,  8'h20, 1'b0, 8'h00, EV_NONE,      8'h00, 8'h00},
			'{OP_JGT,  8'h30, 1'b0, 8'h00, EV_NONE,      8'h00, 8'h00},
			'{OP_DEC0, 8'h00, 1'b0, 8'h00, EV_NONE,      8'h00, 8'h00},
			'{OP_TST,  8'h00, 1'b0, 8'h00, EV_NONE,      8'h00, 8'h00},
			'{OP_JZ,   8'h11, 1'b0, 8'h00, EV_NONE,      8'h00, 8'h00},
			'{OP_JNZ,  8'h22, 1'b0, 8'h00, EV_NONE,      8'h00, 8'h00},
			'{OP_JMP,  8'hFF, 1'b0, 8'h00, EV_NONE,      8'h00, 8'h00},
			'{OP_CALL, 8'h80, 1'b0, 8'h00, EV_NONE,      8'h00, 8'h00},
			'{OP_INT,  8'hFF, 1'b0, 8'h00, EV_NONE,      8'h00, 8'h00},
			'{OP_RET,  8'h00, 1'b0, 8'h00, EV_NONE,      8'h00, 8'h00},
			'{OP_LD0,  8'h00, 1'b0, 8'h00, EV_NONE,      8'h00, 8'h00}
		};

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (plan[i]) begin
			tw = '0;
			tw.npc = plan[i].npc;
			tw.ev = plan[i].ev;
			tw.paddr = plan[i].paddr;
			tw.pval = plan[i].pval;
			issue(plan[i].op, plan[i].arg, plan[i].typed, tw);
		end

		for (int m = 0; m < 3; m++) begin
			idle_mode = m;
			stack_burst();
			for (int i = 0; i < 110; i++) issue_random();
		end

		// hold until every word has drained
		@(negedge clk);
		in_valid = 1'b0;
		while (pending_words.size() != 0) @(posedge clk);
		issue(OP_HALT, 8'($urandom), 1'b0, '0);
		for (int i = 0; i < 4; i++) issue_random();
		@(negedge clk);
		in_valid = 1'b0;
		while (pending_words.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);

		if (mismatches == 0 && pending_words.size() == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/acc_pkg.sv
rtl/acc_ctrl.sv
rtl/acc_dp.sv
rtl/accumulator_cpu_core_top.sv
dv/tb_accumulator_cpu_core_top.sv
